// ===== rtl/triangle_unit_normal_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TUN_CHK_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TUN_CHK_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tun_pkg.sv =====
package tun_pkg;

	// defaults for the top-level parameters
	localparam int COORD_WIDTH_DEF      = 16;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	// largest normalized cross component magnitude lies in [2^60, 2^61)
	localparam int MAG_W       = 61;
	localparam int SPLIT_W     = 32;
	localparam int NORM_STAGES = 6;

	// square root datapath
	localparam int ROOT_W = 62;
	localparam int REM_W  = 64;
	localparam int SUM_W  = 2 * ROOT_W;

	// result component width
	localparam int OUT_W = 16;

	// cross product as sign and magnitude plus degenerate flag
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  degen;
	} nvec_t;

	// sideband that rides along the divider cells
	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} ntag_t;

endpackage

// ===== rtl/tun_norm_cell.sv =====
module tun_norm_cell #(
	parameter int SH = 1
) (
	input  logic           clk,
	input  logic           en,
	input  tun_pkg::nvec_t vec_in,
	output tun_pkg::nvec_t vec_q
);

	logic [3*SH-1:0] top_bits;
	logic            small_mag;
	tun_pkg::nvec_t  nxt;

	// shift all three left together when the top SH bits are clear in all
	always_comb begin
		nxt       = vec_in;
		top_bits  = {vec_in.mag[2][tun_pkg::MAG_W-1 -: SH],
			vec_in.mag[1][tun_pkg::MAG_W-1 -: SH],
			vec_in.mag[0][tun_pkg::MAG_W-1 -: SH]};
		small_mag = ~|top_bits;
		if (small_mag) begin
			for (int i = 0; i < 3; i++) begin
				nxt.mag[i] = vec_in.mag[i] << SH;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= nxt;
		end
	end

endmodule

// ===== rtl/tun_sqrt_cell.sv =====
module tun_sqrt_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tun_pkg::REM_W-1:0]   rem_in,
	input  logic [tun_pkg::ROOT_W-1:0]  root_in,
	input  logic [tun_pkg::SUM_W-1:0]   sum_in,
	input  tun_pkg::nvec_t              vec_in,
	output logic [tun_pkg::REM_W-1:0]   rem_q,
	output logic [tun_pkg::ROOT_W-1:0]  root_q,
	output logic [tun_pkg::SUM_W-1:0]   sum_q,
	output tun_pkg::nvec_t              vec_q
);

	logic [tun_pkg::REM_W+1:0] cur;
	logic [tun_pkg::REM_W+1:0] trial;
	logic [tun_pkg::REM_W+1:0] diff;
	logic                      ge;

	// one root bit: bring down two radicand bits, try root*4+1
	always_comb begin
		cur   = {rem_in, sum_in[tun_pkg::SUM_W-1 -: 2]};
		trial = {{(tun_pkg::REM_W - tun_pkg::ROOT_W){1'b0}}, root_in, 2'b01};
		ge    = (cur >= trial);
		diff  = cur - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[tun_pkg::REM_W-1:0] : cur[tun_pkg::REM_W-1:0];
			root_q <= {root_in[tun_pkg::ROOT_W-2:0], ge};
			sum_q  <= {sum_in[tun_pkg::SUM_W-3:0], 2'b00};
			vec_q  <= vec_in;
		end
	end

endmodule

// ===== rtl/tun_div_cell.sv =====
module tun_div_cell #(
	parameter int QW    = 16,
	parameter bit SHIFT = 1'b1
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [tun_pkg::ROOT_W-1:0]      len_in,
	input  logic [2:0][tun_pkg::ROOT_W:0]   r_in,
	input  logic [2:0][QW-1:0]              q_in,
	input  tun_pkg::ntag_t                  tag_in,
	output logic [tun_pkg::ROOT_W-1:0]      len_q,
	output logic [2:0][tun_pkg::ROOT_W:0]   r_q,
	output logic [2:0][QW-1:0]              q_q,
	output tun_pkg::ntag_t                  tag_q
);

	logic [2:0][tun_pkg::ROOT_W:0] rs;
	logic [2:0][tun_pkg::ROOT_W:0] rn;
	logic [2:0][QW-1:0]            qn;
	logic [tun_pkg::ROOT_W:0]      len_x;
	logic [2:0]                    ge;

	// one quotient bit per component, all three against the same length
	always_comb begin
		len_x = {1'b0, len_in};
		for (int i = 0; i < 3; i++) begin
			rs[i] = SHIFT ? {r_in[i][tun_pkg::ROOT_W-1:0], 1'b0} : r_in[i];
			ge[i] = (rs[i] >= len_x);
			rn[i] = ge[i] ? (rs[i] - len_x) : rs[i];
			qn[i] = {q_in[i][QW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_q <= len_in;
			r_q   <= rn;
			q_q   <= qn;
			tag_q <= tag_in;
		end
	end

endmodule

// ===== rtl/triangle_unit_normal.sv =====
// Unit face normal of a triangle. Each request carries vertices A, B, C
// (signed fixed point); the result is (A-B) x (A-C) scaled to unit length in
// signed fixed point with NORMAL_FRAC_BITS fraction bits, rounded half away from
// zero and saturated to 16 bits; a zero cross product gives a zero normal with
// degenerate set. Fully pipelined through the 62-cell square-root row and the
// NORMAL_FRAC_BITS+2 divider cells: a new request every cycle while no output
// stall is held. An output stall freezes the pipeline; a request is still
// taken while the first stage is empty.
`include "triangle_unit_normal_macros.svh"

module triangle_unit_normal #(
	parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [COORD_WIDTH-1:0]    ax,
	input  logic signed [COORD_WIDTH-1:0]    ay,
	input  logic signed [COORD_WIDTH-1:0]    az,
	input  logic signed [COORD_WIDTH-1:0]    bx,
	input  logic signed [COORD_WIDTH-1:0]    by_coord,
	input  logic signed [COORD_WIDTH-1:0]    bz,
	input  logic signed [COORD_WIDTH-1:0]    cx,
	input  logic signed [COORD_WIDTH-1:0]    cy,
	input  logic signed [COORD_WIDTH-1:0]    cz,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [tun_pkg::OUT_W-1:0] normal_x,
	output logic signed [tun_pkg::OUT_W-1:0] normal_y,
	output logic signed [tun_pkg::OUT_W-1:0] normal_z,
	output logic                             degenerate
);

	localparam int ED      = (COORD_WIDTH > 30) ? 31 : COORD_WIDTH + 1;
	localparam int ESH     = COORD_WIDTH + 1 - ED;
	localparam int PW      = 2 * ED;
	localparam int HI_W    = tun_pkg::MAG_W - tun_pkg::SPLIT_W;
	localparam int SQ_W    = 2 * tun_pkg::MAG_W;
	localparam int QW      = NORMAL_FRAC_BITS + 2;
	localparam int MXW     = (QW > tun_pkg::OUT_W + 1) ? QW : tun_pkg::OUT_W + 1;
	localparam int NEG_LIM = 1 << (tun_pkg::OUT_W - 1);
	localparam int NST     = 4 + tun_pkg::NORM_STAGES + 3 + tun_pkg::ROOT_W + QW;

	// pipeline control: whole row moves unless a result is held
	logic           adv;
	logic           en1;
	logic [NST-1:0] vld_q;

	assign adv      = !out_valid || !out_stall;
	assign en1      = adv || !vld_q[0];
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (en1) begin
				vld_q[0] <= in_valid;
			end
			if (adv) begin
				vld_q[NST-1:1] <= vld_q[NST-2:0];
				out_valid      <= vld_q[NST-1];
			end
		end
	end

	// edge vectors U = A - B, V = A - C
	logic signed [COORD_WIDTH-1:0] a_c [3];
	logic signed [COORD_WIDTH-1:0] b_c [3];
	logic signed [COORD_WIDTH-1:0] c_c [3];
	logic signed [COORD_WIDTH:0]   du  [3];
	logic signed [COORD_WIDTH:0]   dv  [3];
	logic signed [COORD_WIDTH:0]   su  [3];
	logic signed [COORD_WIDTH:0]   sv  [3];
	logic signed [ED-1:0]          u_s1 [3];
	logic signed [ED-1:0]          v_s1 [3];

	always_comb begin
		a_c[0] = ax; a_c[1] = ay;       a_c[2] = az;
		b_c[0] = bx; b_c[1] = by_coord; b_c[2] = bz;
		c_c[0] = cx; c_c[1] = cy;       c_c[2] = cz;
		for (int i = 0; i < 3; i++) begin
			du[i] = $signed({a_c[i][COORD_WIDTH-1], a_c[i]})
				- $signed({b_c[i][COORD_WIDTH-1], b_c[i]});
			dv[i] = $signed({a_c[i][COORD_WIDTH-1], a_c[i]})
				- $signed({c_c[i][COORD_WIDTH-1], c_c[i]});
			su[i] = du[i] >>> ESH;
			sv[i] = dv[i] >>> ESH;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				u_s1[i] <= su[i][ED-1:0];
				v_s1[i] <= sv[i][ED-1:0];
			end
		end
	end

	// six partial products of the cross product
	logic signed [PW-1:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= u_s1[1] * v_s1[2];
			p_s2[1] <= v_s1[1] * u_s1[2];
			p_s2[2] <= v_s1[0] * u_s1[2];
			p_s2[3] <= u_s1[0] * v_s1[2];
			p_s2[4] <= u_s1[0] * v_s1[1];
			p_s2[5] <= v_s1[0] * u_s1[1];
		end
	end

	// cross components
	logic signed [PW:0] n_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= $signed({p_s2[2*i][PW-1], p_s2[2*i]})
					- $signed({p_s2[2*i+1][PW-1], p_s2[2*i+1]});
			end
		end
	end

	// sign and magnitude
	logic [PW:0]    nabs [3];
	tun_pkg::nvec_t vec4_c;
	tun_pkg::nvec_t vec_s4;

	always_comb begin
		vec4_c = '0;
		for (int i = 0; i < 3; i++) begin
			nabs[i]          = n_s3[i][PW] ? -n_s3[i] : n_s3[i];
			vec4_c.mag[i]    = tun_pkg::MAG_W'(nabs[i]);
			vec4_c.neg[i]    = n_s3[i][PW];
		end
		vec4_c.degen = (n_s3[0] == '0) && (n_s3[1] == '0) && (n_s3[2] == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s4 <= vec4_c;
		end
	end

	// normalization row: shifts of 32, 16, 8, 4, 2, 1
	tun_pkg::nvec_t norm_v [tun_pkg::NORM_STAGES+1];

	assign norm_v[0] = vec_s4;

	for (genvar k = 0; k < tun_pkg::NORM_STAGES; k++) begin : g_norm
		tun_norm_cell #(
			.SH(1 << (tun_pkg::NORM_STAGES - 1 - k))
		) u_norm (
			.clk   (clk),
			.en    (adv),
			.vec_in(norm_v[k]),
			.vec_q (norm_v[k+1])
		);
	end

	// squares from split partial products
	logic [2*HI_W-1:0]            hh_s5 [3];
	logic [HI_W+tun_pkg::SPLIT_W-1:0] hl_s5 [3];
	logic [2*tun_pkg::SPLIT_W-1:0]    ll_s5 [3];
	tun_pkg::nvec_t               vec_s5;
	logic [SQ_W-1:0]              sq_s6 [3];
	tun_pkg::nvec_t               vec_s6;
	logic [tun_pkg::SUM_W-1:0]    sum_s7;
	tun_pkg::nvec_t               vec_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= norm_v[tun_pkg::NORM_STAGES].mag[i][tun_pkg::MAG_W-1:tun_pkg::SPLIT_W]
					* norm_v[tun_pkg::NORM_STAGES].mag[i][tun_pkg::MAG_W-1:tun_pkg::SPLIT_W];
				hl_s5[i] <= norm_v[tun_pkg::NORM_STAGES].mag[i][tun_pkg::MAG_W-1:tun_pkg::SPLIT_W]
					* norm_v[tun_pkg::NORM_STAGES].mag[i][tun_pkg::SPLIT_W-1:0];
				ll_s5[i] <= norm_v[tun_pkg::NORM_STAGES].mag[i][tun_pkg::SPLIT_W-1:0]
					* norm_v[tun_pkg::NORM_STAGES].mag[i][tun_pkg::SPLIT_W-1:0];
				sq_s6[i] <= (SQ_W'(hh_s5[i]) << (2 * tun_pkg::SPLIT_W))
					+ (SQ_W'(hl_s5[i]) << (tun_pkg::SPLIT_W + 1))
					+ SQ_W'(ll_s5[i]);
			end
			vec_s5 <= norm_v[tun_pkg::NORM_STAGES];
			vec_s6 <= vec_s5;
			sum_s7 <= tun_pkg::SUM_W'(sq_s6[0]) + tun_pkg::SUM_W'(sq_s6[1])
				+ tun_pkg::SUM_W'(sq_s6[2]);
			vec_s7 <= vec_s6;
		end
	end

	// square-root row, one root bit per cell
	logic [tun_pkg::REM_W-1:0]  rem_c  [tun_pkg::ROOT_W+1];
	logic [tun_pkg::ROOT_W-1:0] root_c [tun_pkg::ROOT_W+1];
	logic [tun_pkg::SUM_W-1:0]  sum_c  [tun_pkg::ROOT_W+1];
	tun_pkg::nvec_t             vec_c  [tun_pkg::ROOT_W+1];

	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign sum_c[0]  = sum_s7;
	assign vec_c[0]  = vec_s7;

	for (genvar k = 0; k < tun_pkg::ROOT_W; k++) begin : g_sqrt
		tun_sqrt_cell u_sqrt (
			.clk    (clk),
			.en     (adv),
			.rem_in (rem_c[k]),
			.root_in(root_c[k]),
			.sum_in (sum_c[k]),
			.vec_in (vec_c[k]),
			.rem_q  (rem_c[k+1]),
			.root_q (root_c[k+1]),
			.sum_q  (sum_c[k+1]),
			.vec_q  (vec_c[k+1])
		);
	end

	// divider row: quotient bit per cell, first cell without shift
	logic [tun_pkg::ROOT_W-1:0]    len_c [QW+1];
	logic [2:0][tun_pkg::ROOT_W:0] r_c   [QW+1];
	logic [2:0][QW-1:0]            q_c   [QW+1];
	tun_pkg::ntag_t                tag_c [QW+1];

	always_comb begin
		len_c[0] = root_c[tun_pkg::ROOT_W];
		q_c[0]   = '0;
		for (int i = 0; i < 3; i++) begin
			r_c[0][i] = (tun_pkg::ROOT_W + 1)'(vec_c[tun_pkg::ROOT_W].mag[i]);
		end
		tag_c[0].neg   = vec_c[tun_pkg::ROOT_W].neg;
		tag_c[0].degen = vec_c[tun_pkg::ROOT_W].degen;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		tun_div_cell #(
			.QW   (QW),
			.SHIFT(k != 0)
		) u_div (
			.clk   (clk),
			.en    (adv),
			.len_in(len_c[k]),
			.r_in  (r_c[k]),
			.q_in  (q_c[k]),
			.tag_in(tag_c[k]),
			.len_q (len_c[k+1]),
			.r_q   (r_c[k+1]),
			.q_q   (q_c[k+1]),
			.tag_q (tag_c[k+1])
		);
	end

	// round half away from zero, apply sign, saturate
	logic [QW:0]                rnd [3];
	logic [MXW-1:0]             mx  [3];
	logic [tun_pkg::OUT_W-1:0]  res [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = {1'b0, q_c[QW][i]} + 1'b1;
			mx[i]  = MXW'(rnd[i][QW:1]);
			if (tag_c[QW].neg[i]) begin
				if (mx[i] > MXW'(NEG_LIM)) begin
					res[i] = {1'b1, {(tun_pkg::OUT_W-1){1'b0}}};
				end else begin
					res[i] = -mx[i][tun_pkg::OUT_W-1:0];
				end
			end else begin
				if (mx[i] > MXW'(NEG_LIM - 1)) begin
					res[i] = {1'b0, {(tun_pkg::OUT_W-1){1'b1}}};
				end else begin
					res[i] = mx[i][tun_pkg::OUT_W-1:0];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			normal_x   <= tag_c[QW].degen ? '0 : res[0];
			normal_y   <= tag_c[QW].degen ? '0 : res[1];
			normal_z   <= tag_c[QW].degen ? '0 : res[2];
			degenerate <= tag_c[QW].degen;
		end
	end

	// checks
	`TUN_CHK_IMP(a_degen_zero, clk, arst_n, out_valid && degenerate,
		normal_x == '0 && normal_y == '0 && normal_z == '0,
		"degenerate result with nonzero normal")
	`TUN_CHK_IMP(a_unit_nonzero, clk, arst_n, out_valid && !degenerate,
		normal_x != '0 || normal_y != '0 || normal_z != '0,
		"non-degenerate result with zero normal")
	`TUN_CHK_IMP(a_stall_cause, clk, arst_n, in_stall,
		out_valid && out_stall && vld_q[0],
		"input stalled without a held result")
	`TUN_CHK_NXT(a_accept_load, clk, arst_n, in_valid && !in_stall, vld_q[0],
		"accepted request not in first stage")

endmodule

// ===== bench/tb_triangle_unit_normal.sv =====
module tb_triangle_unit_normal;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = tun_pkg::COORD_WIDTH_DEF;
	localparam int FB = tun_pkg::NORMAL_FRAC_BITS_DEF;
	localparam int OW = tun_pkg::OUT_W;
	localparam int LATENCY = 77 + FB;
	localparam int N_RANDOM = 1425;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [CW-1:0] coord_t;
	typedef coord_t tri_t [9];

	typedef struct {
		logic signed [OW-1:0] nx, ny, nz;
		logic                 degen;
	} normal_t;

	// expected normal of one triangle
	function automatic normal_t face_normal(tri_t t);
		normal_t    r;
		longint     u[3], v[3], n[3];
		logic [63:0] mag[3];
		logic [63:0] mx, root, q, rem;
		logic [127:0] sq, tt;
		logic [63:0] cand;
		bit         neg[3];
		for (int i = 0; i < 3; i++) begin
			u[i] = longint'(t[i]) - longint'(t[3+i]);
			v[i] = longint'(t[i]) - longint'(t[6+i]);
		end
		n[0] = u[1]*v[2] - v[1]*u[2];
		n[1] = v[0]*u[2] - u[0]*v[2];
		n[2] = u[0]*v[1] - v[0]*u[1];
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = n[i] < 0;
			mag[i] = neg[i] ? -n[i] : n[i];
			if (mag[i] > mx) mx = mag[i];
		end
		r = '{0, 0, 0, 1'b0};
		if (mx == 0) begin
			r.degen = 1'b1;
			return r;
		end
		// normalize so the largest lies in [2^60, 2^61)
		while (mx < (64'd1 << 60)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		sq = 128'(mag[0])*mag[0] + 128'(mag[1])*mag[1] + 128'(mag[2])*mag[2];
		root = 0;
		for (int b = 61; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			tt = 128'(cand) * cand;
			if (tt <= sq) root = cand;
		end
		// long division, then round half away from zero and saturate
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] >= root) ? 1 : 0;
			rem = mag[i] - (q ? root : 0);
			for (int k = 0; k < FB + 1; k++) begin
				rem <<= 1;
				q <<= 1;
				if (rem >= root) begin
					rem -= root;
					q |= 1;
				end
			end
			q = (q + 1) >> 1;
			if (neg[i]) cand = (q > 32768) ? -64'sd32768 : -q;
			else cand = (q > 32767) ? 64'd32767 : q;
			case (i)
				0: r.nx = cand[OW-1:0];
				1: r.ny = cand[OW-1:0];
				default: r.nz = cand[OW-1:0];
			endcase
		end
		return r;
	endfunction

	int n_errors;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	class normal_board;
		normal_t pending_normals[$];
		int      n_checked;
		int      n_degen;

		function void note_request(tri_t t);
			pending_normals.insert(pending_normals.size(), face_normal(t));
		endfunction

		task check_normal(normal_t got);
			normal_t e;
			if (pending_normals.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
				return;
			end
			e = pending_normals.pop_front();
			n_checked++;
			if (e.degen) n_degen++;
			if (got.nx !== e.nx) report_mismatch("normal_x", got.nx, e.nx);
			if (got.ny !== e.ny) report_mismatch("normal_y", got.ny, e.ny);
			if (got.nz !== e.nz) report_mismatch("normal_z", got.nz, e.nz);
			if (got.degen !== e.degen) report_mismatch("degenerate", got.degen, e.degen);
		endtask
	endclass

	normal_board board = new();

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, out_stall = 1'b0;
	logic in_stall, out_valid, degenerate;
	coord_t ax = '0, ay = '0, az = '0, bx = '0, by_coord = '0, bz = '0;
	coord_t cx = '0, cy = '0, cz = '0;
	logic signed [OW-1:0] normal_x, normal_y, normal_z;
	longint cycle_count = 0;
	bit hold_off = 1'b0;
	bit stall_on = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	triangle_unit_normal u_dut (.*);

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: accept and check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_normal('{normal_x, normal_y, normal_z, degenerate});
	end

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if (stall_on) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= 1'b0;
	end

	initial begin
		forever begin
			repeat ($urandom_range(50, 300)) @(posedge clk);
			stall_on = !stall_on;
		end
	end

	// offer one triangle and hold until accepted
	task automatic send_triangle(tri_t t);
		ax <= t[0]; ay <= t[1]; az <= t[2];
		bx <= t[3]; by_coord <= t[4]; bz <= t[5];
		cx <= t[6]; cy <= t[7]; cz <= t[8];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_request(t);
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 15)) - 8;
			2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			default: return coord_t'($urandom_range(0, 2047)) - 1024;
		endcase
	endfunction

	function automatic tri_t rand_triangle();
		tri_t t;
		int  kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			t[i] = rand_coord((kind < 5) ? 0 : (kind < 7) ? 3 : (kind < 9) ? 1 : 2);
		// some degenerate shapes: coincident vertices (B on A, or C on B)
		if ($urandom_range(0, 19) == 0)
			for (int i = 0; i < 3; i++) t[3+i] = t[i];
		else if ($urandom_range(0, 19) == 0)
			for (int i = 0; i < 3; i++) t[6+i] = t[3+i];
		return t;
	endfunction

	tri_t directed[$];

	initial begin
		tri_t t;
		int burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: axis-aligned, extremes, degenerate, tiny and huge edges
		directed = '{
			'{0,0,0, 2048,0,0, 0,2048,0},
			'{0,0,0, 0,2048,0, 2048,0,0},
			'{0,0,0, 0,0,1, 1,0,0},
			'{0,0,0, 0,1,0, 0,0,1},
			'{5,5,5, 5,5,5, 5,5,5},
			'{0,0,0, 1,1,1, 2,2,2},
			'{16'sh7fff,16'sh7fff,16'sh7fff, 16'sh8000,16'sh8000,16'sh8000,
				16'sh8000,16'sh7fff,16'sh8000},
			'{16'sh8000,16'sh8000,16'sh8000, 16'sh7fff,16'sh8000,16'sh8000,
				16'sh8000,16'sh7fff,16'sh8000},
			'{16'sh7fff,0,0, 16'sh8000,0,0, 16'sh7fff,16'sh8000,16'sh7fff},
			'{0,0,0, 1,0,0, 0,16'sh7fff,0},
			'{-1,-1,-1, 0,0,0, -1,0,1},
			'{100,200,300, 400,-500,600, -700,800,-900},
			'{0,0,0, 1,2,0, 2,1,0},
			'{0,0,0, 16'sh5555,16'shaaaa,16'sh5555, 16'shaaaa,16'sh5555,16'sh1234}
		};
		foreach (directed[i]) send_triangle(directed[i]);

		// random bursts with gaps
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				send_triangle(rand_triangle());
				// fill the pipeline against a long hold-off
				if (n == 300) hold_off = 1'b1;
				if (n == 500) begin
					// drain fully before going on
					idle_sender(1);
					while (board.pending_normals.size() != 0) @(posedge clk);
				end
			end
			idle_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
		end
		in_valid <= 1'b0;

		while (board.pending_normals.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);

		$display("Checked %0d normals (%0d degenerate) from random and edge-case triangles,",
			board.n_checked, board.n_degen);
		$display("with random bursts, output stalls and a long back-pressure stretch.");
		if (n_errors == 0 && board.pending_normals.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// long hold-off counted on its own
	initial begin
		wait (hold_off);
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tun_pkg.sv
rtl/tun_norm_cell.sv
rtl/tun_sqrt_cell.sv
rtl/tun_div_cell.sv
rtl/triangle_unit_normal.sv
bench/tb_triangle_unit_normal.sv
